>>> sv/mahcf_pkg.sv
// Shared types, constants and rate tables for the MPEG audio header check block.
package mahcf_pkg;

   localparam logic [11:0] SYNC_WORD        = 12'hFFF;
   localparam logic [31:0] HDR_COMPARE_MASK = 32'h00FF_FCF0;
   localparam logic [31:0] HDR_PADDING_BIT  = 32'h0000_0200;
   localparam logic [15:0] MIN_FRAME_BYTES  = 16'd4;

   localparam logic [1:0] LAYER_RESERVED = 2'd0;
   localparam logic [1:0] LAYER_III      = 2'd1;
   localparam logic [1:0] LAYER_II       = 2'd2;
   localparam logic [1:0] LAYER_I        = 2'd3;

   localparam logic [3:0] BITRATE_FREE = 4'd0;
   localparam logic [3:0] BITRATE_BAD  = 4'd15;
   localparam logic [1:0] RATE_RESERVED = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_BAD_HEADER   = 3'd1,
      STATUS_BAD_RATE     = 3'd2,
      STATUS_CRC          = 3'd3,
      STATUS_FREE_BITRATE = 3'd4,
      STATUS_LAYER_III    = 3'd5,
      STATUS_SIZE         = 3'd6,
      STATUS_TOO_SHORT    = 3'd7
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [10:0] frame_length;
      logic [11:0] duration_ticks;
      logic [10:0] base_length;
      logic        frame_ok;
   } check_type;

   typedef struct packed {
      logic        changed;
      logic        valid;
      logic [31:0] header;
      logic [10:0] length;
   } filler_type;

   // layer I slots (12000 * kbps / fs), rows by sampling index, columns by bitrate index
   localparam logic [7:0] L1_SLOTS [4][16] = '{
      '{8'd0, 8'd8, 8'd17, 8'd26, 8'd34, 8'd43, 8'd52, 8'd60,
        8'd69, 8'd78, 8'd87, 8'd95, 8'd104, 8'd113, 8'd121, 8'd0},
      '{8'd0, 8'd8, 8'd16, 8'd24, 8'd32, 8'd40, 8'd48, 8'd56,
        8'd64, 8'd72, 8'd80, 8'd88, 8'd96, 8'd104, 8'd112, 8'd0},
      '{8'd0, 8'd12, 8'd24, 8'd36, 8'd48, 8'd60, 8'd72, 8'd84,
        8'd96, 8'd108, 8'd120, 8'd132, 8'd144, 8'd156, 8'd168, 8'd0},
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
   };

   // layer II bytes (144000 * kbps / fs) without padding
   localparam logic [10:0] L2_BYTES [4][16] = '{
      '{11'd0, 11'd104, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313, 11'd365,
        11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd1253, 11'd0},
      '{11'd0, 11'd96, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288, 11'd336,
        11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd1152, 11'd0},
      '{11'd0, 11'd144, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432, 11'd504,
        11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd1728, 11'd0},
      '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}
   };

   // frame duration in 90 kHz ticks by sampling index
   localparam logic [11:0] L1_TICKS [4] = '{12'd783, 12'd720, 12'd1080, 12'd0};
   localparam logic [11:0] L2_TICKS [4] = '{12'd2351, 12'd2160, 12'd3240, 12'd0};

endpackage

>>> sv/mpeg_audio_header_check_filler.sv
// MPEG audio layer I/II frame header check with silence-filler header store.
// Each accepted transfer passes through the input register and then the result register, which holds under rsp_stall.
// Throughput: one frame per cycle while rsp_stall is low; the input and result registers each hold one frame.
// Reset: synchronous, active high; clears both valid flags and the filler store.
// The filler store is read and updated in the same cycle as the result register loads.
module mpeg_audio_header_check_filler
   import mahcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_header_word,
   input  logic [15:0] req_frame_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_frame_length,
   output logic [11:0] rsp_duration_ticks,
   output logic        rsp_filler_changed,
   output logic        rsp_filler_valid,
   output logic [31:0] rsp_filler_header,
   output logic [10:0] rsp_filler_length
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] in_header_ff;
   logic [15:0] in_bytes_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        out_open;
   logic        out_load;
   logic        in_open;
   check_type   check;
   filler_type  filler;
   check_type   check_ff;
   filler_type  filler_ff;

   assign out_open    = !rsp_valid_ff || !rsp_stall;
   assign out_load    = in_valid_ff && out_open;
   assign in_open     = !in_valid_ff || out_load;
   assign req_stall   = !in_open;
   assign in_valid_in = in_open ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_open ? in_valid_ff : rsp_valid_ff;

   mahcf_check u_check (
      .header_word (in_header_ff),
      .frame_bytes (in_bytes_ff),
      .check       (check)
   );

   mahcf_filler u_filler (
      .clock       (clock),
      .reset       (reset),
      .step        (out_load),
      .frame_ok    (check.frame_ok),
      .header_word (in_header_ff),
      .base_length (check.base_length),
      .filler      (filler)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_open) begin
         in_header_ff <= req_header_word;
         in_bytes_ff  <= req_frame_bytes;
      end
      if (out_load) begin
         check_ff  <= check;
         filler_ff <= filler;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = check_ff.status;
   assign rsp_frame_length   = check_ff.frame_length;
   assign rsp_duration_ticks = check_ff.duration_ticks;
   assign rsp_filler_changed = filler_ff.changed;
   assign rsp_filler_valid   = filler_ff.valid;
   assign rsp_filler_header  = filler_ff.header;
   assign rsp_filler_length  = filler_ff.length;

endmodule

>>> sv/mahcf_check.sv
// Header field checks, frame length and duration lookup for one frame.
module mahcf_check
   import mahcf_pkg::*;
(
   input  logic [31:0] header_word,
   input  logic [15:0] frame_bytes,
   output check_type   check
);

   logic [11:0] sync;
   logic [1:0]  layer;
   logic        prot;
   logic [3:0]  bri;
   logic [1:0]  sfi;
   logic        pad;
   logic [7:0]  slots;
   logic [7:0]  slots_pad;
   logic [10:0] len_l1;
   logic [10:0] base_l1;
   logic [10:0] len_l2;
   logic [10:0] base_l2;
   logic [10:0] calc_len;
   logic [10:0] calc_base;
   logic [11:0] calc_ticks;

   assign sync  = header_word[31:20];
   assign layer = header_word[18:17];
   assign prot  = header_word[16];
   assign bri   = header_word[15:12];
   assign sfi   = header_word[11:10];
   assign pad   = header_word[9];

   assign slots     = L1_SLOTS[sfi][bri];
   assign slots_pad = slots + {7'd0, pad};
   assign len_l1    = {1'b0, slots_pad, 2'b00};
   assign base_l1   = {1'b0, slots, 2'b00};
   assign base_l2   = L2_BYTES[sfi][bri];
   assign len_l2    = base_l2 + {10'd0, pad};

   assign calc_len   = (layer == LAYER_I) ? len_l1 : len_l2;
   assign calc_base  = (layer == LAYER_I) ? base_l1 : base_l2;
   assign calc_ticks = (layer == LAYER_I) ? L1_TICKS[sfi] : L2_TICKS[sfi];

   always_comb begin
      check.status         = STATUS_OK;
      check.frame_length   = '0;
      check.duration_ticks = '0;
      check.base_length    = calc_base;
      check.frame_ok       = 1'b0;
      if (frame_bytes < MIN_FRAME_BYTES) begin
         check.status = STATUS_TOO_SHORT;
      end else if (sync != SYNC_WORD || layer == LAYER_RESERVED || bri == BITRATE_BAD) begin
         check.status = STATUS_BAD_HEADER;
      end else if (sfi == RATE_RESERVED) begin
         check.status = STATUS_BAD_RATE;
      end else if (!prot) begin
         check.status = STATUS_CRC;
      end else if (bri == BITRATE_FREE) begin
         check.status = STATUS_FREE_BITRATE;
      end else if (!(layer inside {LAYER_I, LAYER_II})) begin
         check.status = STATUS_LAYER_III;
      end else begin
         check.frame_length = calc_len;
         if ({5'd0, calc_len} != frame_bytes) begin
            check.status = STATUS_SIZE;
         end else begin
            check.duration_ticks = calc_ticks;
            check.frame_ok       = 1'b1;
         end
      end
   end

endmodule

>>> sv/mahcf_filler.sv
// Silence-filler header store with change detection.
module mahcf_filler
   import mahcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        frame_ok,
   input  logic [31:0] header_word,
   input  logic [10:0] base_length,
   output filler_type  filler
);

   logic        present_ff;
   logic        present_in;
   logic [31:0] header_ff;
   logic [31:0] header_in;
   logic [10:0] length_ff;
   logic [10:0] length_in;
   logic        changed;

   assign changed = frame_ok &&
      (!present_ff || (header_word & HDR_COMPARE_MASK) != (header_ff & HDR_COMPARE_MASK));

   always_comb begin
      present_in = present_ff;
      header_in  = header_ff;
      length_in  = length_ff;
      if (changed) begin
         present_in = 1'b1;
         header_in  = header_word & ~HDR_PADDING_BIT;
         length_in  = base_length;
      end
   end

   assign filler.changed = changed;
   assign filler.valid   = present_in;
   assign filler.header  = header_in;
   assign filler.length  = length_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         header_ff  <= '0;
         length_ff  <= '0;
      end else if (step) begin
         present_ff <= present_in;
         header_ff  <= header_in;
         length_ff  <= length_in;
      end
   end

endmodule

>>> sv/mahcf_sva.sv
// Port-level checker for the MPEG audio header check block and its bind.
module mahcf_sva
   import mahcf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [10:0] rsp_frame_length,
   input logic [11:0] rsp_duration_ticks,
   input logic        rsp_filler_changed,
   input logic        rsp_filler_valid,
   input logic [31:0] rsp_filler_header,
   input logic [10:0] rsp_filler_length
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_filler_header))
      else $error("result changed while stalled");

   a_change_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filler_changed |->
         rsp_status == STATUS_OK && rsp_filler_valid && !rsp_filler_header[9])
      else $error("filler replaced by a failed frame");

   a_ticks_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_duration_ticks == 12'd0)
      else $error("duration given for a failed frame");

   a_length_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK && rsp_status != STATUS_SIZE
         |-> rsp_frame_length == 11'd0)
      else $error("frame length given for a rejected header");

   a_filler_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filler_valid |-> rsp_filler_length != 11'd0)
      else $error("filler present with zero length");

endmodule

bind mpeg_audio_header_check_filler mahcf_sva u_mahcf_sva (.*);

>>> test/tb_top.sv
// Testbench for the MPEG audio header check and filler store: drivers, scoreboard, final check.
`timescale 1ns / 1ps

module tb_top;
   import mahcf_pkg::*;

   class filler_scoreboard;
      typedef struct {
         status_type  status;
         logic [10:0] frame_length;
         logic [11:0] duration_ticks;
         logic        changed;
         logic        present;
         logic [31:0] header;
         logic [10:0] length;
      } frame_result;

      frame_result expected_q[$];
      logic [31:0] filler_header;
      logic [10:0] filler_length;
      logic        filler_present;
      int unsigned mismatches;

      function new();
         filler_header  = '0;
         filler_length  = '0;
         filler_present = 1'b0;
         mismatches     = 0;
      endfunction

      static function int unsigned sample_rate(logic [1:0] sfi);
         case (sfi)
            2'd0:    return 44100;
            2'd1:    return 48000;
            default: return 32000;
         endcase
      endfunction

      static function int unsigned bitrate_kbps(logic [1:0] layer, logic [3:0] bri);
         int unsigned layer1_kbps [15] = '{0, 32, 64, 96, 128, 160, 192, 224,
                                           256, 288, 320, 352, 384, 416, 448};
         int unsigned layer2_kbps [15] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                           128, 160, 192, 224, 256, 320, 384};
         if (bri == BITRATE_BAD)
            return 0;
         return (layer == LAYER_I) ? layer1_kbps[bri] : layer2_kbps[bri];
      endfunction

      static function logic [10:0] frame_len(logic [1:0] layer, logic [3:0] bri,
                                             logic [1:0] sfi, logic pad);
         int unsigned kbps;
         int unsigned fs;
         kbps = bitrate_kbps(layer, bri);
         fs   = sample_rate(sfi);
         if (layer == LAYER_I)
            return 11'((kbps * 12000 / fs + pad) * 4);
         return 11'(144000 * kbps / fs + pad);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_frame(logic [31:0] hw, logic [15:0] nbytes);
         frame_result r;
         logic [1:0]  layer;
         logic [1:0]  sfi;
         logic [3:0]  bri;
         int unsigned fs;
         layer = hw[18:17];
         bri   = hw[15:12];
         sfi   = hw[11:10];
         r.status         = STATUS_OK;
         r.frame_length   = '0;
         r.duration_ticks = '0;
         r.changed        = 1'b0;
         if (nbytes < MIN_FRAME_BYTES)
            r.status = STATUS_TOO_SHORT;
         else if (hw[31:20] != SYNC_WORD || layer == LAYER_RESERVED || bri == BITRATE_BAD)
            r.status = STATUS_BAD_HEADER;
         else if (sfi == RATE_RESERVED)
            r.status = STATUS_BAD_RATE;
         else if (!hw[16])
            r.status = STATUS_CRC;
         else if (bri == BITRATE_FREE)
            r.status = STATUS_FREE_BITRATE;
         else if (layer == LAYER_III)
            r.status = STATUS_LAYER_III;
         else begin
            r.frame_length = frame_len(layer, bri, sfi, hw[9]);
            if (16'(r.frame_length) != nbytes)
               r.status = STATUS_SIZE;
            else begin
               fs = sample_rate(sfi);
               r.duration_ticks = 12'(90000 * ((layer == LAYER_I) ? 384 : 1152) / fs);
               if (!filler_present ||
                   (hw & HDR_COMPARE_MASK) != (filler_header & HDR_COMPARE_MASK)) begin
                  filler_header  = hw & ~HDR_PADDING_BIT;
                  filler_length  = frame_len(layer, bri, sfi, 1'b0);
                  filler_present = 1'b1;
                  r.changed      = 1'b1;
               end
            end
         end
         r.present = filler_present;
         r.header  = filler_header;
         r.length  = filler_length;
         expected_q.push_back(r);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         if (mismatches < 200)
            $display("mismatch: %s got %0h expected %0h at %0t", field, got, want, $time);
         mismatches++;
      endtask

      task check_result(frame_result got);
         frame_result want;
         if (expected_q.size() == 0) begin
            report("transfer with nothing expected, status", got.status, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report("status", got.status, want.status);
         if (got.frame_length !== want.frame_length)
            report("frame_length", got.frame_length, want.frame_length);
         if (got.duration_ticks !== want.duration_ticks)
            report("duration_ticks", got.duration_ticks, want.duration_ticks);
         if (got.changed !== want.changed)
            report("filler_changed", got.changed, want.changed);
         if (got.present !== want.present)
            report("filler_valid", got.present, want.present);
         if (got.header !== want.header)
            report("filler_header", got.header, want.header);
         if (got.length !== want.length)
            report("filler_length", got.length, want.length);
      endtask
   endclass

   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_header_word = '0;
   logic [15:0] req_frame_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_frame_length;
   logic [11:0] rsp_duration_ticks;
   logic        rsp_filler_changed;
   logic        rsp_filler_valid;
   logic [31:0] rsp_filler_header;
   logic [10:0] rsp_filler_length;

   logic        rsp_idling = 1'b1;
   logic        rsp_holding = 1'b0;
   bit          sender_idling = 1'b1;
   int          quiet_cycles = 0;
   logic [31:0] stream_pool [4];

   filler_scoreboard frame_sb;

   mpeg_audio_header_check_filler u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_header_word    (req_header_word),
      .req_frame_bytes    (req_frame_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_filler_changed (rsp_filler_changed),
      .rsp_filler_valid   (rsp_filler_valid),
      .rsp_filler_header  (rsp_filler_header),
      .rsp_filler_length  (rsp_filler_length)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= rsp_holding || (rsp_idling && $urandom_range(99) < 28);
   end

   always @(posedge clock) begin
      filler_scoreboard::frame_result got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status         = status_type'(rsp_status);
         got.frame_length   = rsp_frame_length;
         got.duration_ticks = rsp_duration_ticks;
         got.changed        = rsp_filler_changed;
         got.present        = rsp_filler_valid;
         got.header         = rsp_filler_header;
         got.length         = rsp_filler_length;
         frame_sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL mpeg_audio_header_check_filler");
         $finish;
      end
   end

   function automatic logic [31:0] make_header(logic id, logic [1:0] layer, logic [3:0] bri,
                                               logic [1:0] sfi, logic pad, logic [8:0] low);
      return {SYNC_WORD, id, layer, 1'b1, bri, sfi, pad, low};
   endfunction

   function automatic logic [15:0] good_length(logic [31:0] hw);
      return 16'(filler_scoreboard::frame_len(hw[18:17], hw[15:12], hw[11:10], hw[9]));
   endfunction

   function automatic logic [31:0] random_stream();
      return make_header(1'($urandom), $urandom_range(1) ? LAYER_I : LAYER_II,
                         4'($urandom_range(1, 14)), 2'($urandom_range(2)), 1'b0,
                         9'($urandom));
   endfunction

   task automatic hold_receiver(int cycles);
      rsp_holding <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_holding <= 1'b0;
   endtask

   task automatic offer(logic [31:0] hw, logic [15:0] nb);
      while (sender_idling && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_header_word <= hw;
      req_frame_bytes <= nb;
      do
         @(posedge clock);
      while (req_stall);
      frame_sb.note_frame(hw, nb);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      logic [31:0] hw;
      offer(32'h0000_0000, 16'd0);
      offer(32'hFFFF_FFFF, 16'd3);
      offer(32'hFFFF_FFFF, 16'hFFFF);
      offer(32'h0000_0000, 16'hFFFF);
      offer(make_header(1'b1, LAYER_RESERVED, 4'd4, 2'd0, 1'b0, 9'h0), 16'd100);
      offer(make_header(1'b1, LAYER_II, 4'd4, RATE_RESERVED, 1'b0, 9'h0), 16'd100);
      offer(make_header(1'b1, LAYER_II, 4'd4, 2'd0, 1'b0, 9'h0) & ~32'h0001_0000, 16'd208);
      offer(make_header(1'b1, LAYER_II, BITRATE_FREE, 2'd0, 1'b0, 9'h0), 16'd208);
      offer(make_header(1'b1, LAYER_III, 4'd5, 2'd1, 1'b0, 9'h0), 16'd240);
      hw = make_header(1'b1, LAYER_II, 4'd14, 2'd0, 1'b1, 9'h000);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_II, 4'd14, 2'd0, 1'b0, 9'h10F);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_II, 4'd14, 2'd0, 1'b0, 9'h0C0);
      offer(hw, good_length(hw));
      offer(hw, good_length(hw) + 16'd1);
      offer(hw, 16'hFFFF);
      offer(hw, 16'd4);
      hw = make_header(1'b0, LAYER_II, 4'd14, 2'd0, 1'b0, 9'h0C0);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_I, 4'd14, 2'd2, 1'b1, 9'h1FF);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_I, 4'd1, 2'd0, 1'b0, 9'h030);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_I, 4'd7, 2'd1, 1'b1, 9'h000);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_II, 4'd14, 2'd2, 1'b1, 9'h000);
      offer(hw, good_length(hw));
      hw = make_header(1'b1, LAYER_II, 4'd1, 2'd1, 1'b0, 9'h000);
      offer(hw, good_length(hw));
   endtask

   task automatic run_random(int count);
      logic [31:0] hw;
      logic [15:0] nb;
      int          pick;
      int          k;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 5)
            stream_pool[$urandom_range(3)] = random_stream();
         hw       = stream_pool[$urandom_range(3)];
         hw[9:8]  = 2'($urandom);
         hw[3:0]  = 4'($urandom);
         nb       = good_length(hw);
         pick     = $urandom_range(99);
         if (pick >= 60 && pick < 64)
            nb = nb + 16'd1;
         else if (pick >= 64 && pick < 67)
            nb = nb - 16'd1;
         else if (pick >= 67 && pick < 70)
            nb = 16'($urandom);
         else if (pick >= 70 && pick < 80) begin
            case ($urandom_range(5))
               0: begin
                  k = $urandom_range(11);
                  hw[20 + k] = ~hw[20 + k];
               end
               1: hw[18:17] = LAYER_RESERVED;
               2: hw[18:17] = LAYER_III;
               3: hw[15:12] = $urandom_range(1) ? BITRATE_FREE : BITRATE_BAD;
               4: hw[11:10] = RATE_RESERVED;
               default: hw[16] = 1'b0;
            endcase
            if ($urandom_range(1))
               nb = 16'($urandom_range(4, 2000));
         end else if (pick >= 80 && pick < 90) begin
            hw = $urandom;
            nb = 16'($urandom);
         end else if (pick >= 90 && pick < 95)
            nb = 16'($urandom_range(3));
         else if (pick >= 95) begin
            hw = $urandom;
            nb = 16'($urandom_range(4, 1800));
         end
         offer(hw, nb);
      end
   endtask

   initial begin
      frame_sb = new();
      for (int i = 0; i < 4; i++)
         stream_pool[i] = random_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(650);
      // fill the block while the receiver holds off
      sender_idling = 1'b0;
      fork
         hold_receiver(150);
      join_none
      run_random(40);
      drain();
      rsp_idling <= 1'b0;
      run_random(350);
      rsp_idling   <= 1'b1;
      sender_idling = 1'b1;
      run_random(690);
      drain();
      repeat (10) @(posedge clock);
      if (frame_sb.mismatches == 0 && frame_sb.pending() == 0)
         $display("PASS mpeg_audio_header_check_filler");
      else
         $display("FAIL mpeg_audio_header_check_filler");
      $finish;
   end

endmodule

>>> filelist.f
sv/mahcf_pkg.sv
sv/mahcf_check.sv
sv/mahcf_filler.sv
sv/mpeg_audio_header_check_filler.sv
sv/mahcf_sva.sv
test/tb_top.sv
